// ===== hdl/scc_pkg.sv =====
// Shared types and codes for the strongly connected components block.
// Used by scc_out_reg and strongly_connected_components; no dependencies.
package scc_pkg;

    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;

    // Command codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Result kinds
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_MEMBER = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] component;
        logic              last_of_component;
        logic              last;
    } t_out;

endpackage

// ===== hdl/scc_out_reg.sv =====
// Output register for result transactions of the component search block.
// Depends on scc_pkg for the result struct.
module scc_out_reg
    import scc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_out i_data,
    output logic o_ready,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic r_valid;
    t_out r_data;

    // Free when empty or when the held transaction leaves this cycle
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Hold valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload on load only
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hdl/strongly_connected_components.sv =====
// Tarjan component search over a graph held in on-chip adjacency lists.
// An add edge is range-checked, written unless its list is full, then acknowledged;
// a clear is acknowledged directly. A run tries each root in turn, visits each node
// (reading its degree), scans its edges, reports members, then resumes its parent.
// No new command is taken until the current one has loaded its results into the output register.
// Synchronous reset empties the graph (degree valid bits), node_count to 1.
module strongly_connected_components
    import scc_pkg::*;
#(
    parameter int MAX_NODES  = 64,
    parameter int MAX_DEGREE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in                i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out               o_out,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int MSW = $clog2(MAX_NODES);
    localparam int CSW = $clog2(MAX_NODES + 1);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = $clog2(MAX_NODES * MAX_DEGREE);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_WR = 4'd1;
    localparam logic [3:0] S_ACK    = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_DEG_RD = 4'd4;
    localparam logic [3:0] S_DEG_WT = 4'd5;
    localparam logic [3:0] S_LOOP   = 4'd6;
    localparam logic [3:0] S_ADJ    = 4'd7;
    localparam logic [3:0] S_DISC   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_POP_RD = 4'd10;
    localparam logic [3:0] S_POP    = 4'd11;
    localparam logic [3:0] S_RET    = 4'd12;
    localparam logic [3:0] S_PAR    = 4'd13;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [DW-1:0]      pos;
        logic [COUNT_W-1:0] disc;
        logic [COUNT_W-1:0] low;
    } t_frame;

    // Memories
    logic [NODE_W-1:0]  m_adj  [MAX_NODES*MAX_DEGREE];
    logic [DW-1:0]      m_deg  [MAX_NODES];
    logic [COUNT_W-1:0] m_disc [MAX_NODES];
    logic [NODE_W-1:0]  m_ms   [MAX_NODES];
    t_frame             m_cs   [MAX_NODES];

    // Control registers
    logic [3:0]           r_state, n_state;
    logic [COUNT_W-1:0]   r_node_count;
    logic [MAX_NODES-1:0] r_deg_vld, n_deg_vld;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [MAX_NODES-1:0] r_onstk, n_onstk;
    logic [COUNT_W-1:0]   r_vc, n_vc;
    logic [NODE_W-1:0]    r_comp, n_comp;
    logic [CSW-1:0]       r_msp, n_msp;
    logic [CSW-1:0]       r_csp, n_csp;
    logic [COUNT_W-1:0]   r_root, n_root;

    // Working registers of the top frame
    logic [NODE_W-1:0]  r_u, n_u;
    logic [NODE_W-1:0]  r_w, n_w;
    logic [DW-1:0]      r_pos, n_pos;
    logic [DW-1:0]      r_deg, n_deg;
    logic [COUNT_W-1:0] r_disc, n_disc;
    logic [COUNT_W-1:0] r_low, n_low;
    logic [1:0]         r_status, n_status;

    // Read data
    logic [NODE_W-1:0]  r_adj_rd;
    logic [DW-1:0]      r_deg_rd;
    logic               r_deg_rd_v;
    logic [COUNT_W-1:0] r_disc_rd;
    logic [NODE_W-1:0]  r_ms_rd;
    t_frame             r_cs_rd;

    // Memory controls
    logic               adj_we, deg_we, disc_we, ms_we, cs_we;
    logic [AW-1:0]      adj_waddr, adj_raddr;
    logic [NODE_W-1:0]  adj_wdata;
    logic [MSW-1:0]     deg_waddr, deg_raddr;
    logic [DW-1:0]      deg_wdata;
    logic [MSW-1:0]     disc_waddr;
    logic [COUNT_W-1:0] disc_wdata;
    logic [MSW-1:0]     ms_waddr;
    logic [NODE_W-1:0]  ms_wdata;
    logic [MSW-1:0]     cs_waddr;
    t_frame             cs_wdata;

    logic [COUNT_W-1:0] n_use;
    logic               in_acc;
    logic               out_ready;
    logic               out_load;
    t_out               out_data;
    logic               do_visit;
    logic               do_push;
    logic [NODE_W-1:0]  v_node;
    logic [COUNT_W-1:0] vc_inc;
    logic [CSW-1:0]     cs_wptr, cs_rptr, ms_rptr;
    logic [DW-1:0]      deg_cur;

    assign n_use = (r_node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                         : r_node_count;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign cs_wptr   = r_csp - CSW'(1);
    assign cs_rptr   = r_csp - CSW'(2);
    assign ms_rptr   = r_msp - CSW'(1);
    assign adj_raddr = AW'(r_u[MSW-1:0]) * AW'(MAX_DEGREE) + AW'(r_pos);
    assign deg_raddr = (r_state == S_IDLE) ? i_in.src_node[MSW-1:0] : r_u[MSW-1:0];
    assign deg_cur   = r_deg_rd_v ? r_deg_rd : '0;
    assign vc_inc    = r_vc + COUNT_W'(1);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_deg_vld = r_deg_vld;
        n_visited = r_visited;
        n_onstk   = r_onstk;
        n_vc      = r_vc;
        n_comp    = r_comp;
        n_msp     = r_msp;
        n_csp     = r_csp;
        n_root    = r_root;
        n_u       = r_u;
        n_w       = r_w;
        n_pos     = r_pos;
        n_deg     = r_deg;
        n_disc    = r_disc;
        n_low     = r_low;
        n_status  = r_status;
        adj_we    = 1'b0;
        adj_waddr = AW'(r_u[MSW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_cur);
        adj_wdata = r_w;
        deg_we    = 1'b0;
        deg_waddr = r_u[MSW-1:0];
        deg_wdata = deg_cur + DW'(1);
        disc_we   = 1'b0;
        disc_waddr = r_u[MSW-1:0];
        disc_wdata = vc_inc;
        ms_we     = 1'b0;
        ms_waddr  = r_msp[MSW-1:0];
        ms_wdata  = '0;
        cs_we     = 1'b0;
        cs_waddr  = cs_wptr[MSW-1:0];
        cs_wdata  = '{node: r_u, pos: r_pos, disc: r_disc, low: r_low};
        out_load  = 1'b0;
        out_data  = '0;
        do_visit  = 1'b0;
        do_push   = 1'b0;
        v_node    = r_adj_rd;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.opcode)
                        OP_ADD: begin
                            n_u = i_in.src_node;
                            n_w = i_in.dst_node;
                            if ({1'b0, i_in.src_node} >= n_use ||
                                {1'b0, i_in.dst_node} >= n_use) begin
                                n_status = ST_RANGE;
                                n_state  = S_ACK;
                            end else begin
                                n_state = S_ADD_WR;
                            end
                        end
                        OP_RUN: begin
                            n_visited = '0;
                            n_onstk   = '0;
                            n_vc      = '0;
                            n_comp    = '0;
                            n_msp     = '0;
                            n_csp     = '0;
                            n_root    = '0;
                            n_state   = S_ROOT;
                        end
                        OP_CLR: begin
                            n_deg_vld = '0;
                            n_status  = ST_OK;
                            n_state   = S_ACK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                if (deg_cur >= DW'(MAX_DEGREE)) begin
                    n_status = ST_FULL;
                end else begin
                    adj_we = 1'b1;
                    deg_we = 1'b1;
                    n_deg_vld[r_u[MSW-1:0]] = 1'b1;
                    n_status = ST_OK;
                end
                n_state = S_ACK;
            end
            S_ACK: begin
                if (out_ready) begin
                    out_load        = 1'b1;
                    out_data.kind   = KIND_ACK;
                    out_data.status = r_status;
                    out_data.last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ROOT: begin
                if (r_root >= n_use) begin
                    n_state = S_IDLE;
                end else if (r_visited[r_root[MSW-1:0]]) begin
                    n_root = r_root + COUNT_W'(1);
                end else begin
                    do_visit = 1'b1;
                    v_node   = r_root[NODE_W-1:0];
                    n_csp    = CSW'(1);
                    n_state  = S_DEG_RD;
                end
            end
            S_DEG_RD: begin
                n_state = S_DEG_WT;
            end
            S_DEG_WT: begin
                n_deg   = deg_cur;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_pos < r_deg) begin
                    n_pos   = r_pos + DW'(1);
                    n_state = S_ADJ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADJ: begin
                if ({1'b0, r_adj_rd} >= n_use) begin
                    n_state = S_LOOP;
                end else if (!r_visited[r_adj_rd[MSW-1:0]]) begin
                    do_visit = 1'b1;
                    do_push  = 1'b1;
                    n_csp    = r_csp + CSW'(1);
                    n_state  = S_DEG_RD;
                end else if (r_onstk[r_adj_rd[MSW-1:0]]) begin
                    n_state = S_DISC;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_DISC: begin
                if (r_disc_rd < r_low) begin
                    n_low = r_disc_rd;
                end
                n_state = S_LOOP;
            end
            S_FIN: begin
                n_state = (r_low == r_disc) ? S_POP_RD : S_RET;
            end
            S_POP_RD: begin
                n_state = S_POP;
            end
            S_POP: begin
                if (out_ready) begin
                    out_load                   = 1'b1;
                    out_data.kind              = KIND_MEMBER;
                    out_data.status            = ST_OK;
                    out_data.node              = r_ms_rd;
                    out_data.component         = r_comp;
                    out_data.last_of_component = (r_ms_rd == r_u);
                    out_data.last = (r_ms_rd == r_u) && (r_csp == CSW'(1)) &&
                                    (r_vc == n_use);
                    n_msp = ms_rptr;
                    n_onstk[r_ms_rd[MSW-1:0]] = 1'b0;
                    if (r_ms_rd == r_u) begin
                        n_comp  = r_comp + NODE_W'(1);
                        n_state = S_RET;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end
            end
            S_RET: begin
                n_csp   = cs_wptr;
                n_state = (r_csp > CSW'(1)) ? S_PAR : S_ROOT;
            end
            S_PAR: begin
                n_u     = r_cs_rd.node;
                n_pos   = r_cs_rd.pos;
                n_disc  = r_cs_rd.disc;
                n_low   = (r_low < r_cs_rd.low) ? r_low : r_cs_rd.low;
                n_state = S_DEG_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Enter a node: number it, push it, open its frame
        if (do_visit) begin
            n_vc       = vc_inc;
            disc_we    = 1'b1;
            disc_waddr = v_node[MSW-1:0];
            ms_we      = 1'b1;
            ms_wdata   = v_node;
            n_msp      = r_msp + CSW'(1);
            n_onstk[v_node[MSW-1:0]]   = 1'b1;
            n_visited[v_node[MSW-1:0]] = 1'b1;
            cs_we      = do_push;
            n_u        = v_node;
            n_pos      = '0;
            n_disc     = vc_inc;
            n_low      = vc_inc;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= COUNT_W'(1);
            r_deg_vld    <= '0;
            r_visited    <= '0;
            r_onstk      <= '0;
            r_vc         <= '0;
            r_comp       <= '0;
            r_msp        <= '0;
            r_csp        <= '0;
            r_root       <= '0;
        end else begin
            r_state   <= n_state;
            r_deg_vld <= n_deg_vld;
            r_visited <= n_visited;
            r_onstk   <= n_onstk;
            r_vc      <= n_vc;
            r_comp    <= n_comp;
            r_msp     <= n_msp;
            r_csp     <= n_csp;
            r_root    <= n_root;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    // Frame and status registers
    always_ff @(posedge i_clk) begin
        r_u      <= n_u;
        r_w      <= n_w;
        r_pos    <= n_pos;
        r_deg    <= n_deg;
        r_disc   <= n_disc;
        r_low    <= n_low;
        r_status <= n_status;
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            m_adj[adj_waddr] <= adj_wdata;
        end
        r_adj_rd <= m_adj[adj_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            m_deg[deg_waddr] <= deg_wdata;
        end
        r_deg_rd   <= m_deg[deg_raddr];
        r_deg_rd_v <= r_deg_vld[deg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (disc_we) begin
            m_disc[disc_waddr] <= disc_wdata;
        end
        r_disc_rd <= m_disc[r_adj_rd[MSW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ms_we) begin
            m_ms[ms_waddr] <= ms_wdata;
        end
        r_ms_rd <= m_ms[ms_rptr[MSW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            m_cs[cs_waddr] <= cs_wdata;
        end
        r_cs_rd <= m_cs[cs_rptr[MSW-1:0]];
    end

    scc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_data  (out_data),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_stall (i_out_stall)
    );

    // A finished run leaves both stacks empty
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_csp == '0 && r_msp == '0))
        else $error("stacks not empty while idle");

    // Every open frame's node sits on the member stack; a closing frame
    // may already have popped its own node
    a_csp_le_msp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RET) ? (r_csp <= r_msp + CSW'(1)) : (r_csp <= r_msp)) &&
        (r_msp <= CSW'(MAX_NODES)))
        else $error("stack depth out of order");

    // No more visits than nodes in use during a run
    a_vc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_ACK && r_state != S_ADD_WR)
        |-> (r_vc <= n_use))
        else $error("visit counter beyond node count");

endmodule
